// ===== hw/rtl/bsc_pkg.sv =====
// bsc_pkg: shared types, widths and constants of the barometric compensation pipeline.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

    // Stage counts of the two pipeline sections
    localparam int FRONT_STAGES = 6;
    localparam int PRESS_STAGES = 5;

    // Field widths
    localparam int RAW_W      = 24;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int SPLIT_W    = 20;   // low slice of SENS for the split multiply

    // Arithmetic constants
    localparam int TEMP_REF         = 2000;
    localparam int TEMP_SHIFT       = 23;
    localparam int OFF_SHIFT        = 7;
    localparam int SENS_SHIFT       = 8;
    localparam int T2_SHIFT         = 31;
    localparam int P1_SHIFT         = 21;
    localparam int P2_SHIFT         = 15;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C1 = 8'd0,
        CFG_C2 = 8'd1,
        CFG_C3 = 8'd2,
        CFG_C4 = 8'd3,
        CFG_C5 = 8'd4,
        CFG_C6 = 8'd5
    } t_cfg_idx;

    typedef logic        [RAW_W-1:0]  t_raw;
    typedef logic        [COEF_W-1:0] t_coef;
    typedef logic signed [24:0]       t_dt;     // D2 - C5*256
    typedef logic signed [41:0]       t_mul;    // dT times a coefficient
    typedef logic signed [49:0]       t_dd;     // dT squared
    typedef logic signed [18:0]       t_tq;     // TEMP - 2000 before correction
    typedef logic        [17:0]       t_t2;
    typedef logic signed [37:0]       t_sqm;    // product width of the square
    typedef logic        [34:0]       t_sq;
    typedef logic        [37:0]       t_sq5;
    typedef logic signed [19:0]       t_temp;
    typedef logic signed [39:0]       t_wide;   // OFF and SENS
    typedef logic        [43:0]       t_plo;
    typedef logic signed [44:0]       t_phi;
    typedef logic signed [63:0]       t_prod;
    typedef logic signed [42:0]       t_px;
    typedef logic signed [43:0]       t_py;
    typedef logic signed [31:0]       t_press;
    typedef logic signed [18:0]       t_tout;

    // Rounding biases for truncation toward zero
    localparam t_mul  TEMP_BIAS = t_mul'((1 << TEMP_SHIFT) - 1);
    localparam t_mul  OFF_BIAS  = t_mul'((1 << OFF_SHIFT) - 1);
    localparam t_mul  SENS_BIAS = t_mul'((1 << SENS_SHIFT) - 1);
    localparam t_prod P1_BIAS   = t_prod'((1 << P1_SHIFT) - 1);
    localparam t_py   P2_BIAS   = t_py'((1 << P2_SHIFT) - 1);

    typedef struct packed {
        t_coef c1;
        t_coef c2;
        t_coef c3;
        t_coef c4;
        t_coef c5;
        t_coef c6;
    } t_cfg;

    // Handoff from the temperature/offset section to the pressure section
    typedef struct packed {
        t_raw  d1;
        t_temp temp;
        t_wide off;
        t_wide sens;
    } t_front;

endpackage

`default_nettype wire

// ===== hw/rtl/bsc_cfg_regs.sv =====
// bsc_cfg_regs: the six calibration word registers behind the configuration channel.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_cfg_regs (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [bsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [bsc_pkg::COEF_W-1:0]    i_cfg_data,
    output bsc_pkg::t_cfg               o_cfg
);

    bsc_pkg::t_cfg r_cfg, n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (bsc_pkg::t_cfg_idx'(i_cfg_index))
                bsc_pkg::CFG_C1: n_cfg.c1 = i_cfg_data;
                bsc_pkg::CFG_C2: n_cfg.c2 = i_cfg_data;
                bsc_pkg::CFG_C3: n_cfg.c3 = i_cfg_data;
                bsc_pkg::CFG_C4: n_cfg.c4 = i_cfg_data;
                bsc_pkg::CFG_C5: n_cfg.c5 = i_cfg_data;
                bsc_pkg::CFG_C6: n_cfg.c6 = i_cfg_data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsc_front.sv =====
// bsc_front: six-stage section computing dT, TEMP, OFF and SENS with the
// second-order correction. Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  bsc_pkg::t_cfg        i_cfg,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire [bsc_pkg::RAW_W-1:0] i_raw_p,
    input  wire [bsc_pkg::RAW_W-1:0] i_raw_t,
    output logic                 o_valid,
    input  wire                  i_ready,
    output bsc_pkg::t_front      o_data
);

    localparam int NS = bsc_pkg::FRONT_STAGES;

    logic [NS-1:0] r_v, n_v, en;

    // stage 1
    bsc_pkg::t_raw  r1_d1;
    bsc_pkg::t_dt   r1_dt, n1_dt;
    // stage 2
    bsc_pkg::t_raw  r2_d1;
    bsc_pkg::t_mul  r2_mt, r2_mo, r2_ms, n2_mt, n2_mo, n2_ms;
    bsc_pkg::t_dd   r2_dd, n2_dd;
    // stage 3
    bsc_pkg::t_raw  r3_d1;
    bsc_pkg::t_mul  n3_mtb, n3_mob, n3_msb;
    bsc_pkg::t_tq   r3_q, n3_q;
    bsc_pkg::t_wide r3_off, r3_sens, n3_off, n3_sens;
    bsc_pkg::t_t2   r3_t2, n3_t2;
    // stage 4
    bsc_pkg::t_raw  r4_d1;
    bsc_pkg::t_temp r4_temp, n4_temp;
    logic           r4_neg;
    bsc_pkg::t_sq   r4_sq, n4_sq;
    bsc_pkg::t_wide r4_off, r4_sens;
    // stage 5
    bsc_pkg::t_raw  r5_d1;
    bsc_pkg::t_temp r5_temp;
    logic           r5_neg;
    bsc_pkg::t_sq5  r5_sq5, n5_sq5;
    bsc_pkg::t_wide r5_off, r5_sens;
    // stage 6
    bsc_pkg::t_front r6_out, n6_out;

    // A stage moves when it is empty or the one after it moves
    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
        n_v[0] = en[0] ? i_valid : r_v[0];
        for (int k = 1; k < NS; k++) begin
            n_v[k] = en[k] ? r_v[k-1] : r_v[k];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_data  = r6_out;

    always_comb begin
        n1_dt = $signed({1'b0, i_raw_t}) - $signed({1'b0, i_cfg.c5, 8'h00});

        n2_mt = bsc_pkg::t_mul'(r1_dt) * bsc_pkg::t_mul'($signed({1'b0, i_cfg.c6}));
        n2_mo = bsc_pkg::t_mul'(r1_dt) * bsc_pkg::t_mul'($signed({1'b0, i_cfg.c4}));
        n2_ms = bsc_pkg::t_mul'(r1_dt) * bsc_pkg::t_mul'($signed({1'b0, i_cfg.c3}));
        n2_dd = bsc_pkg::t_dd'(r1_dt) * bsc_pkg::t_dd'(r1_dt);

        // power-of-two divides truncate toward zero: bias negatives first
        n3_mtb  = r2_mt + (r2_mt[$bits(r2_mt)-1] ? bsc_pkg::TEMP_BIAS : '0);
        n3_mob  = r2_mo + (r2_mo[$bits(r2_mo)-1] ? bsc_pkg::OFF_BIAS : '0);
        n3_msb  = r2_ms + (r2_ms[$bits(r2_ms)-1] ? bsc_pkg::SENS_BIAS : '0);
        n3_q    = bsc_pkg::t_tq'(n3_mtb >>> bsc_pkg::TEMP_SHIFT);
        n3_off  = bsc_pkg::t_wide'({i_cfg.c2, 16'h0000})
                + bsc_pkg::t_wide'(n3_mob >>> bsc_pkg::OFF_SHIFT);
        n3_sens = bsc_pkg::t_wide'({i_cfg.c1, 15'h0000})
                + bsc_pkg::t_wide'(n3_msb >>> bsc_pkg::SENS_SHIFT);
        n3_t2   = bsc_pkg::t_t2'(r2_dd >>> bsc_pkg::T2_SHIFT);

        // TEMP below 20.00 C exactly when the first-order delta is negative
        n4_sq   = bsc_pkg::t_sq'(bsc_pkg::t_sqm'(r3_q) * bsc_pkg::t_sqm'(r3_q));
        n4_temp = bsc_pkg::t_temp'(r3_q) + bsc_pkg::t_temp'(bsc_pkg::TEMP_REF)
                - (r3_q[$bits(r3_q)-1] ? bsc_pkg::t_temp'(r3_t2) : '0);

        n5_sq5 = bsc_pkg::t_sq5'(r4_sq) + (bsc_pkg::t_sq5'(r4_sq) << 2);

        n6_out.d1   = r5_d1;
        n6_out.temp = r5_temp;
        n6_out.off  = r5_off - (r5_neg ? bsc_pkg::t_wide'(r5_sq5 >> 1) : '0);
        n6_out.sens = r5_sens - (r5_neg ? bsc_pkg::t_wide'(r5_sq5 >> 2) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_d1 <= i_raw_p;
            r1_dt <= n1_dt;
        end
        if (en[1]) begin
            r2_d1 <= r1_d1;
            r2_mt <= n2_mt;
            r2_mo <= n2_mo;
            r2_ms <= n2_ms;
            r2_dd <= n2_dd;
        end
        if (en[2]) begin
            r3_d1   <= r2_d1;
            r3_q    <= n3_q;
            r3_off  <= n3_off;
            r3_sens <= n3_sens;
            r3_t2   <= n3_t2;
        end
        if (en[3]) begin
            r4_d1   <= r3_d1;
            r4_temp <= n4_temp;
            r4_neg  <= r3_q[$bits(r3_q)-1];
            r4_sq   <= n4_sq;
            r4_off  <= r3_off;
            r4_sens <= r3_sens;
        end
        if (en[4]) begin
            r5_d1   <= r4_d1;
            r5_temp <= r4_temp;
            r5_neg  <= r4_neg;
            r5_sq5  <= n5_sq5;
            r5_off  <= r4_off;
            r5_sens <= r4_sens;
        end
        if (en[5]) begin
            r6_out <= n6_out;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsc_press.sv =====
// bsc_press: five-stage section forming P = (D1*SENS/2^21 - OFF)/2^15 with a
// split multiply. Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_press (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  bsc_pkg::t_front  i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output bsc_pkg::t_tout   o_temp,
    output bsc_pkg::t_press  o_press
);

    localparam int NS = bsc_pkg::PRESS_STAGES;

    logic [NS-1:0] r_v, n_v, en;

    bsc_pkg::t_temp  r1_temp, r2_temp, r3_temp, r4_temp, r5_temp;
    bsc_pkg::t_wide  r1_off, r2_off, r3_off;
    bsc_pkg::t_plo   r1_plo, n1_plo;
    bsc_pkg::t_phi   r1_phi, n1_phi;
    bsc_pkg::t_prod  r2_prod, n2_prod, n3_pb;
    bsc_pkg::t_px    r3_px, n3_px;
    bsc_pkg::t_py    r4_py, n4_py, n5_pyb;
    bsc_pkg::t_press r5_press, n5_press;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
        n_v[0] = en[0] ? i_valid : r_v[0];
        for (int k = 1; k < NS; k++) begin
            n_v[k] = en[k] ? r_v[k-1] : r_v[k];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_temp  = bsc_pkg::t_tout'(r5_temp);
    assign o_press = r5_press;

    always_comb begin
        // D1*SENS as unsigned low slice plus signed high slice
        n1_plo = bsc_pkg::t_plo'(i_data.d1)
               * bsc_pkg::t_plo'(i_data.sens[bsc_pkg::SPLIT_W-1:0]);
        n1_phi = bsc_pkg::t_phi'($signed({1'b0, i_data.d1}))
               * bsc_pkg::t_phi'($signed(i_data.sens[$bits(i_data.sens)-1:bsc_pkg::SPLIT_W]));

        n2_prod = (bsc_pkg::t_prod'(r1_phi) <<< bsc_pkg::SPLIT_W) + bsc_pkg::t_prod'(r1_plo);

        n3_pb = r2_prod + (r2_prod[$bits(r2_prod)-1] ? bsc_pkg::P1_BIAS : '0);
        n3_px = bsc_pkg::t_px'(n3_pb >>> bsc_pkg::P1_SHIFT);

        n4_py = bsc_pkg::t_py'(r3_px) - bsc_pkg::t_py'(r3_off);

        n5_pyb   = r4_py + (r4_py[$bits(r4_py)-1] ? bsc_pkg::P2_BIAS : '0);
        n5_press = bsc_pkg::t_press'(n5_pyb >>> bsc_pkg::P2_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_temp <= i_data.temp;
            r1_off  <= i_data.off;
            r1_plo  <= n1_plo;
            r1_phi  <= n1_phi;
        end
        if (en[1]) begin
            r2_temp <= r1_temp;
            r2_off  <= r1_off;
            r2_prod <= n2_prod;
        end
        if (en[2]) begin
            r3_temp <= r2_temp;
            r3_off  <= r2_off;
            r3_px   <= n3_px;
        end
        if (en[3]) begin
            r4_temp <= r3_temp;
            r4_py   <= n4_py;
        end
        if (en[4]) begin
            r5_temp  <= r4_temp;
            r5_press <= n5_press;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/baro_sensor_compensation.sv =====
// baro_sensor_compensation: top level; config registers, front section and
// pressure section. Depends on bsc_pkg, bsc_cfg_regs, bsc_front, bsc_press.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  raw_pressure, raw_temperature
//  m_axis    out        m_axis_tvalid / m_axis_tready  temperature_centi, pressure_pa
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One transfer per cycle in and out while m_axis does not stall; the pipe has
// 6 front + 5 pressure stages.
// i_rst_n clears all stage valid bits and the six calibration words to zero.
// When m_axis stalls, empty stages still fill, so up to 11 items are held
// before s_axis_tready drops. Config writes complete every cycle.
`timescale 1ns / 1ps
`default_nettype none

module baro_sensor_compensation (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [47:0]  s_axis_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [18:0] temperature_centi, [50:19] pressure_pa
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [7:0]   i_cfg_index,
    input  wire [15:0]  i_cfg_data
);

    bsc_pkg::t_cfg   cfg;
    bsc_pkg::t_front front_data;
    logic            front_valid;
    logic            press_ready;
    bsc_pkg::t_tout  temp_out;
    bsc_pkg::t_press press_out;

    bsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_raw_p (s_axis_tdata[23:0]),
        .i_raw_t (s_axis_tdata[47:24]),
        .o_valid (front_valid),
        .i_ready (press_ready),
        .o_data  (front_data)
    );

    bsc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (press_ready),
        .i_data  (front_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_temp  (temp_out),
        .o_press (press_out)
    );

    assign m_axis_tdata = {5'b00000, press_out, temp_out};

    // Back-pressure only ever comes from a full pipe behind a stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && front_valid))
        else $error("input stalled without a blocked output");

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !front_valid))
        else $error("result valid right after reset");

    // A pipe whose front and pressure outputs are both idle cannot stall the input
    a_ready_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid && !front_valid) |-> s_axis_tready)
        else $error("input stalled while pipe outputs idle");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for baro_sensor_compensation: calibration phases, directed
// corner pairs and random pairs under several idle/stall mixes. Depends on bsc_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int C5_SCALE_SH   = 8;
    localparam int OFF_SCALE_SH  = 16;
    localparam int SENS_SCALE_SH = 15;
    localparam int RAW_MAX       = (1 << bsc_pkg::RAW_W) - 1;
    localparam int DRAIN_CYCLES  = bsc_pkg::FRONT_STAGES + bsc_pkg::PRESS_STAGES + 4;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        bsc_pkg::t_tout  temp;
        bsc_pkg::t_press press;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [55:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    wire         o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    baro_sensor_compensation i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    bsc_pkg::t_cfg cal = '0;               // calibration words as the block holds them
    logic [47:0]   pending_pairs[$];       // {raw_temperature, raw_pressure}
    t_reading      expected_readings[$];
    int            n_pushed = 0;
    int            n_checked = 0;
    int            fail_count = 0;
    int            src_idle_pct = 0;
    int            snk_stall_pct = 0;
    bit            hold_go = 1'b0;
    logic          hold_rx = 1'b0;
    t_reading      got_r;
    t_reading      want_r;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // Compensated temperature and pressure for one raw pair under the current calibration.
    function automatic t_reading predict_reading(input bsc_pkg::t_raw d1,
                                                 input bsc_pkg::t_raw d2);
        longint   d1l, dt, temp, off, sens, diff, sq, p;
        t_reading r;
        d1l  = longint'({40'd0, d1});
        dt   = longint'({40'd0, d2}) - (longint'({48'd0, cal.c5}) << C5_SCALE_SH);
        temp = bsc_pkg::TEMP_REF
             + (dt * longint'({48'd0, cal.c6})) / (longint'(1) << bsc_pkg::TEMP_SHIFT);
        off  = (longint'({48'd0, cal.c2}) << OFF_SCALE_SH)
             + (longint'({48'd0, cal.c4}) * dt) / (longint'(1) << bsc_pkg::OFF_SHIFT);
        sens = (longint'({48'd0, cal.c1}) << SENS_SCALE_SH)
             + (longint'({48'd0, cal.c3}) * dt) / (longint'(1) << bsc_pkg::SENS_SHIFT);
        if (temp < bsc_pkg::TEMP_REF) begin
            // second-order correction below 20.00 C
            diff = temp - bsc_pkg::TEMP_REF;
            sq   = diff * diff;
            temp = temp - ((dt * dt) >>> bsc_pkg::T2_SHIFT);
            off  = off - ((5 * sq) >>> 1);
            sens = sens - ((5 * sq) >>> 2);
        end
        p = ((d1l * sens) / (longint'(1) << bsc_pkg::P1_SHIFT) - off)
          / (longint'(1) << bsc_pkg::P2_SHIFT);
        r.temp  = temp[18:0];
        r.press = p[31:0];
        return r;
    endfunction

    function automatic bsc_pkg::t_raw clamp_raw(input longint v);
        if (v < 0)
            return '0;
        if (v > RAW_MAX)
            return bsc_pkg::t_raw'(RAW_MAX);
        return bsc_pkg::t_raw'(v);
    endfunction

    // Input driver: one transfer per accepted pair, expectation taken at acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_readings.push_back(
                    predict_reading(s_axis_tdata[23:0], s_axis_tdata[47:24]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_pairs.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_r.temp  = m_axis_tdata[18:0];
                got_r.press = m_axis_tdata[50:19];
                if (expected_readings.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected transfer, expected none, actual temp %0d press %0d",
                             $time, got_r.temp, got_r.press);
                end else begin
                    want_r = expected_readings.pop_front();
                    n_checked++;
                    if (got_r.temp !== want_r.temp) begin
                        fail_count++;
                        $display("%0t: temperature_centi expected %0d actual %0d",
                                 $time, want_r.temp, got_r.temp);
                    end
                    if (got_r.press !== want_r.press) begin
                        fail_count++;
                        $display("%0t: pressure_pa expected %0d actual %0d",
                                 $time, want_r.press, got_r.press);
                    end
                end
            end
            m_axis_tready <= !hold_rx && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Long receiver hold-off so the pipeline fills and backs up its input.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    task automatic write_reg(input logic [7:0] idx, input bsc_pkg::t_coef val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            bsc_pkg::CFG_C1: cal.c1 = val;
            bsc_pkg::CFG_C2: cal.c2 = val;
            bsc_pkg::CFG_C3: cal.c3 = val;
            bsc_pkg::CFG_C4: cal.c4 = val;
            bsc_pkg::CFG_C5: cal.c5 = val;
            bsc_pkg::CFG_C6: cal.c6 = val;
            default: ;
        endcase
    endtask

    task automatic load_cal(input bsc_pkg::t_cfg c);
        write_reg(bsc_pkg::CFG_C1, c.c1);
        write_reg(bsc_pkg::CFG_C2, c.c2);
        write_reg(bsc_pkg::CFG_C3, c.c3);
        write_reg(bsc_pkg::CFG_C4, c.c4);
        write_reg(bsc_pkg::CFG_C5, c.c5);
        write_reg(bsc_pkg::CFG_C6, c.c6);
        // index past the last register must leave the calibration alone
        write_reg(8'($urandom_range(255, int'(bsc_pkg::CFG_C6) + 1)),
                  bsc_pkg::t_coef'($urandom));
    endtask

    function automatic bsc_pkg::t_coef pick_coef();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return bsc_pkg::t_coef'($urandom);
        endcase
    endfunction

    task automatic push_pair(input bsc_pkg::t_raw d1, input bsc_pkg::t_raw d2);
        pending_pairs.push_back({d2, d1});
        n_pushed++;
    endtask

    task automatic push_directed(input bit with_edges);
        longint ref_d2, dt_b;
        push_pair('0, '0);
        push_pair('1, '1);
        push_pair('0, '1);
        push_pair('1, '0);
        if (with_edges) begin
            ref_d2 = longint'({48'd0, cal.c5}) << C5_SCALE_SH;
            push_pair('1, clamp_raw(ref_d2));
            if (cal.c6 != 0) begin
                // first dT that lands on 19.99 C, and the one just above at 20.00 C
                dt_b = -(((longint'(1) << bsc_pkg::TEMP_SHIFT) + cal.c6 - 1) / cal.c6);
                push_pair(bsc_pkg::t_raw'($urandom), clamp_raw(ref_d2 + dt_b));
                push_pair(bsc_pkg::t_raw'($urandom), clamp_raw(ref_d2 + dt_b + 1));
            end
        end
    endtask

    task automatic push_random(input int n);
        longint span, ref_d2;
        repeat (n) begin
            if ($urandom_range(3) == 0) begin
                push_pair(bsc_pkg::t_raw'($urandom), bsc_pkg::t_raw'($urandom));
            end else begin
                // raw temperature near the reference so both branches get hit
                ref_d2 = longint'({48'd0, cal.c5}) << C5_SCALE_SH;
                span   = longint'(1) << $urandom_range(20, 4);
                push_pair(bsc_pkg::t_raw'($urandom),
                          clamp_raw(ref_d2 + longint'($urandom_range(2 * span)) - span));
            end
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
            default: begin src_idle_pct = 26; snk_stall_pct = 26; end
        endcase
    endtask

    task automatic drain();
        do @(posedge i_clk); while (n_checked != n_pushed);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        bsc_pkg::t_cfg c;
        wait (i_rst_n);
        @(posedge i_clk);

        // reset calibration, all zero
        @(negedge i_clk);
        push_directed(1'b0);
        drain();

        c = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
              c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
        load_cal(c);
        @(negedge i_clk);
        push_directed(1'b1);
        drain();

        load_cal('1);
        @(negedge i_clk);
        push_directed(1'b1);
        drain();

        c = '{c1: 16'hFFFF, c2: 16'h0000, c3: 16'hFFFF,
              c4: 16'h0000, c5: 16'hFFFF, c6: 16'hFFFF};
        load_cal(c);
        @(negedge i_clk);
        push_directed(1'b1);
        drain();

        for (int k = 0; k < 8; k++) begin
            c = '{c1: pick_coef(), c2: pick_coef(), c3: pick_coef(),
                  c4: pick_coef(), c5: pick_coef(), c6: pick_coef()};
            load_cal(c);
            @(negedge i_clk);
            set_idling(k % 4);
            if (k == 4)
                hold_go = 1'b1;
            push_random(190);
            drain();
        end

        if (fail_count == 0 && expected_readings.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
